// File: src/fwan_pkg.sv
// fwan_pkg: shared types, constants and the codepoint map of the fullwidth normalizer
// used by fwan_step, fwan_outbuf and fullwidth_to_ascii_normalizer_top
// depends on nothing
`timescale 1ns / 1ps

package fwan_pkg;

   localparam int unsigned MAX_OUT = 3;

   localparam logic [7:0]  LEAD_MIN      = 8'hC2;
   localparam logic [7:0]  LEAD_MAX      = 8'hEF;
   localparam logic [7:0]  LEAD_3BYTE    = 8'hE0;
   localparam logic [15:0] CP_3BYTE_MIN  = 16'h0800;
   localparam logic [15:0] CP_IDEO_SPACE = 16'h3000;

   // held sequence bytes
   typedef struct packed {
      logic [7:0] lead;
      logic [7:0] second;
      logic [1:0] count;
   } held_type;

   // group of result bytes made by one item, data[0] goes out first
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] data;
      logic [1:0]              count;
      logic                    last;
   } group_type;

   function automatic group_type push_byte(group_type grp, logic [7:0] value);
      group_type res;
      res = grp;
      if (grp.count < 2'(MAX_OUT)) begin
         res.data[grp.count] = value;
         res.count           = grp.count + 2'd1;
      end
      return res;
   endfunction

   function automatic logic is_cont(logic [7:0] value);
      return value[7:6] == 2'b10;
   endfunction

   // ascii replacement of a listed codepoint, zero when not listed
   function automatic logic [7:0] map_cp(logic [15:0] cp);
      logic [7:0] res;
      res = 8'h00;
      case (cp) inside
         CP_IDEO_SPACE:         res = 8'h20;
         [16'hFF10:16'hFF19]:   res = 8'h30 + {4'h0, cp[3:0]};
         [16'hFF21:16'hFF23]:   res = 8'h41 + (cp[7:0] - 8'h21);
         [16'hFF41:16'hFF43]:   res = 8'h41 + (cp[7:0] - 8'h41);
         16'hFF08:              res = 8'h28;
         16'hFF09:              res = 8'h29;
         16'hFF1A:              res = 8'h3A;
         16'hFF0B:              res = 8'h2B;
         16'hFF20:              res = 8'h40;
         16'hFF0E:              res = 8'h2E;
         16'hFF0F:              res = 8'h2F;
         16'hFF0D:              res = 8'h2D;
         16'hFF58:              res = 8'h78;
         16'hFF49:              res = 8'h69;
         16'hFF44:              res = 8'h64;
         16'hFF55:              res = 8'h75;
         16'hFF45:              res = 8'h65;
         16'hFF50:              res = 8'h70;
         16'hFF4E:              res = 8'h6E;
         default:               res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

// File: src/fwan_step.sv
// fwan_step: combinational decode of one byte against the held sequence
// gives the result group and the next held state; uses fwan_pkg
`timescale 1ns / 1ps

module fwan_step (
   input  fwan_pkg::held_type  held,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output fwan_pkg::held_type  held_next,
   output fwan_pkg::group_type grp
);

   logic                     fresh_hold;
   logic [15:0]              cp;
   logic [7:0]               mapped;

   always_comb begin
      fresh_hold = (in_byte >= fwan_pkg::LEAD_MIN) && (in_byte <= fwan_pkg::LEAD_MAX);
      cp         = {held.lead[3:0], held.second[5:0], in_byte[5:0]};
      mapped     = (cp < fwan_pkg::CP_3BYTE_MIN) ? 8'h00 : fwan_pkg::map_cp(cp);
   end

   always_comb begin
      fwan_pkg::group_type g;
      fwan_pkg::held_type  h;
      logic                scan;
      g       = '0;
      h       = held;
      h.count = 2'd0;
      scan    = 1'b0;

      case (held.count)
         2'd1: begin
            if (!fwan_pkg::is_cont(in_byte)) begin
               g    = fwan_pkg::push_byte(g, held.lead);
               scan = 1'b1;
            end else if (held.lead < fwan_pkg::LEAD_3BYTE) begin
               g = fwan_pkg::push_byte(g, held.lead);
               g = fwan_pkg::push_byte(g, in_byte);
            end else begin
               h.second = in_byte;
               h.count  = 2'd2;
            end
         end
         2'd2: begin
            if (!fwan_pkg::is_cont(in_byte)) begin
               g    = fwan_pkg::push_byte(g, held.lead);
               g    = fwan_pkg::push_byte(g, held.second);
               scan = 1'b1;
            end else if (mapped != 8'h00) begin
               g = fwan_pkg::push_byte(g, mapped);
            end else begin
               g = fwan_pkg::push_byte(g, held.lead);
               g = fwan_pkg::push_byte(g, held.second);
               g = fwan_pkg::push_byte(g, in_byte);
            end
         end
         default: begin
            // nothing held, the unreachable count of three included
            scan = 1'b1;
         end
      endcase

      // fresh scan of the byte as a possible lead
      if (scan) begin
         if (fresh_hold) begin
            h.lead   = in_byte;
            h.second = 8'h00;
            h.count  = 2'd1;
         end else begin
            g = fwan_pkg::push_byte(g, in_byte);
         end
      end

      // end of line flushes what is still held
      if (in_last) begin
         if (h.count != 2'd0) g = fwan_pkg::push_byte(g, h.lead);
         if (h.count == 2'd2) g = fwan_pkg::push_byte(g, h.second);
         h      = '0;
         g.last = 1'b1;
      end

      held_next = h;
      grp       = g;
   end

endmodule

// File: src/fwan_outbuf.sv
// fwan_outbuf: result register holding one group of up to three bytes
// sends them one per cycle on the result channel while rsp_tready is high; uses fwan_pkg
`timescale 1ns / 1ps

module fwan_outbuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  fwan_pkg::group_type load_grp,
   output logic                load_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   logic [fwan_pkg::MAX_OUT-1:0][7:0] data_ff, data_in;
   logic [1:0]                        count_ff, count_in;
   logic                              last_ff, last_in;
   logic                              pop;

   always_comb begin
      rsp_tvalid = count_ff != 2'd0;
      rsp_tdata  = data_ff[0];
      rsp_tlast  = last_ff && (count_ff == 2'd1);
      pop        = rsp_tvalid && rsp_tready;
      load_ready = (count_ff == 2'd0) || (pop && (count_ff == 2'd1));

      data_in  = data_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (load_valid && load_ready) begin
         data_in  = load_grp.data;
         count_in = load_grp.count;
         last_in  = load_grp.last;
      end else if (pop) begin
         // shift next byte to the head
         data_in  = {8'h00, data_ff[fwan_pkg::MAX_OUT-1:1]};
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule

// File: src/fullwidth_to_ascii_normalizer_top.sv
// fullwidth_to_ascii_normalizer_top: utf-8 fullwidth to ascii normalizer, top level
// input register, held-sequence state, fwan_step decode, fwan_outbuf result register
// uses fwan_pkg
`timescale 1ns / 1ps

// channel   dir  width  contents
// req_*     in   8+1    tdata = in_byte, tlast = in_last
// rsp_*     out  8+1    tdata = out_byte, tlast = out_last
//
// one item enters per cycle as long as each item yields at most one byte and the
// result channel is ready; an item that yields two or three bytes holds up the input
// register until its last byte is being taken, since the result register sends one
// byte per cycle; an accepted item passes the input register and then the result
// register before its first byte is driven
// reset clears the input valid flag, the held count and the result count
// rsp_tready low stalls the result register and, behind it, the input register

module fullwidth_to_ascii_normalizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);

   // input register
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                in_last_ff, in_last_in;
   logic                in_valid_ff, in_valid_in;

   // held sequence
   fwan_pkg::held_type  held_ff, held_in;
   fwan_pkg::held_type  held_next;
   fwan_pkg::group_type grp;

   logic                load_ready;
   logic                consume;

   fwan_step u_step (
      .held      (held_ff),
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .held_next (held_next),
      .grp       (grp)
   );

   // an item with no result byte still needs a free result register slot
   // only to keep the order simple; it never loads it
   assign consume    = in_valid_ff && load_ready;
   assign req_tready = !in_valid_ff || consume;

   fwan_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load_valid (consume && (grp.count != 2'd0)),
      .load_grp   (grp),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      in_valid_in = in_valid_ff && !consume;
      if (req_tvalid && req_tready) begin
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
         in_valid_in = 1'b1;
      end
      held_in = consume ? held_next : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         held_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         held_ff     <= held_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

endmodule

// File: sim/fullwidth_to_ascii_normalizer_top_tb.sv
// fullwidth_to_ascii_normalizer_top_tb: self-checking bench of the utf-8 fullwidth normalizer
// directed line tests, then random well-formed and broken lines under bursty traffic
// drives fullwidth_to_ascii_normalizer_top, which needs fwan_pkg, fwan_step and fwan_outbuf
`timescale 1ns / 1ps

module fullwidth_to_ascii_normalizer_top_tb;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rsp_item_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_kind_type;

   typedef enum int {
      SEQ_ASCII, SEQ_LISTED, SEQ_THREE, SEQ_TWO, SEQ_NOISE, SEQ_BROKEN
   } seq_kind_type;

   localparam int RANDOM_ITEMS = 185;
   localparam int DRAIN_CYCLES = 20;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   // normalized bytes still to come out, oldest first
   rsp_item_type pending_bytes[$];

   // shadow copy of the sequence holder
   logic [7:0] shadow_lead;
   logic [7:0] shadow_second;
   logic [1:0] shadow_count;

   logic [7:0] step_bytes[3];
   int         step_n;

   int errors;
   int items_sent;
   int results_seen;
   int lines_sent;
   int burst_left;

   stall_kind_type stall_mode;
   int             stall_phase;
   int             stall_hold;

   fullwidth_to_ascii_normalizer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ascii replacement of an allowlisted codepoint, zero otherwise
   function automatic logic [7:0] fullwidth_ascii(input logic [15:0] cp);
      logic [7:0] res;
      res = 8'h00;
      if (cp == 16'h3000)
         res = " ";
      else if (cp >= 16'hFF10 && cp <= 16'hFF19)
         res = 8'(8'h30 + (cp - 16'hFF10));
      else if (cp >= 16'hFF21 && cp <= 16'hFF23)
         res = 8'(8'h41 + (cp - 16'hFF21));
      else if (cp >= 16'hFF41 && cp <= 16'hFF43)
         res = 8'(8'h41 + (cp - 16'hFF41));   // lowercase a..c map to uppercase
      else begin
         case (cp)
            16'hFF08: res = "(";
            16'hFF09: res = ")";
            16'hFF1A: res = ":";
            16'hFF0B: res = "+";
            16'hFF20: res = "@";
            16'hFF0E: res = ".";
            16'hFF0F: res = "/";
            16'hFF0D: res = "-";
            16'hFF58: res = "x";
            16'hFF49: res = "i";
            16'hFF44: res = "d";
            16'hFF55: res = "u";
            16'hFF45: res = "e";
            16'hFF50: res = "p";
            16'hFF4E: res = "n";
            default:  res = 8'h00;
         endcase
      end
      return res;
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      if (step_n < 3) begin
         step_bytes[step_n] = b;
         step_n++;
      end
   endfunction

   // byte met with nothing held: ascii and bad leads go out, good leads are held
   function automatic void scan_lead(input logic [7:0] b);
      if (b < 8'h80)
         emit_byte(b);
      else if (b >= 8'hC2 && b <= 8'hEF) begin
         shadow_lead   = b;
         shadow_second = 8'h00;
         shadow_count  = 2'd1;
      end else
         emit_byte(b);
   endfunction

   // advance the shadow holder by one accepted item and queue its output bytes
   function automatic void normalize_byte(input logic [7:0] b, input logic line_end);
      logic [7:0]   lead;
      logic [7:0]   sec;
      logic [15:0]  cp;
      logic [7:0]   repl;
      rsp_item_type item;
      step_n = 0;
      lead   = shadow_lead;
      sec    = shadow_second;
      case (shadow_count)
         2'd1: begin
            shadow_count = 2'd0;
            if (b[7:6] != 2'b10) begin
               emit_byte(lead);
               scan_lead(b);
            end else if (lead < 8'hE0) begin
               emit_byte(lead);
               emit_byte(b);
            end else begin
               shadow_second = b;
               shadow_count  = 2'd2;
            end
         end
         2'd2: begin
            shadow_count = 2'd0;
            if (b[7:6] != 2'b10) begin
               emit_byte(lead);
               emit_byte(sec);
               scan_lead(b);
            end else begin
               cp   = {lead[3:0], sec[5:0], b[5:0]};
               repl = (cp < 16'h0800) ? 8'h00 : fullwidth_ascii(cp);
               if (repl != 8'h00)
                  emit_byte(repl);
               else begin
                  emit_byte(lead);
                  emit_byte(sec);
                  emit_byte(b);
               end
            end
         end
         default: begin
            // a count of three cannot happen, treated as empty
            shadow_count = 2'd0;
            scan_lead(b);
         end
      endcase
      if (line_end) begin
         if (shadow_count >= 2'd1) emit_byte(shadow_lead);
         if (shadow_count == 2'd2) emit_byte(shadow_second);
         shadow_count  = 2'd0;
         shadow_lead   = 8'h00;
         shadow_second = 8'h00;
      end
      for (int i = 0; i < step_n; i++) begin
         item.data = step_bytes[i];
         item.last = line_end && (i == step_n - 1);
         pending_bytes.push_back(item);
      end
   endfunction

   // offer one item, wait for it to be taken, then maybe leave a gap
   task automatic send_item(input logic [7:0] b, input logic line_end);
      int gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = line_end;
      do @(posedge clock); while (!req_tready);
      normalize_byte(b, line_end);
      items_sent++;
      if (line_end) lines_sent++;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end else
         burst_left--;
   endtask

   task automatic release_bus;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // hold the sender until every queued byte has come out
   task automatic wait_drained;
      release_bus();
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic test_ascii_extremes;
      send_item(8'h00, 1'b0);
      send_item(8'h7F, 1'b1);
   endtask

   task automatic test_listed_codepoints;
      send_item(8'hE3, 1'b0);   // ideographic space
      send_item(8'h80, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'hEF, 1'b0);   // fullwidth a, goes out uppercase
      send_item(8'hBD, 1'b0);
      send_item(8'h81, 1'b1);
   endtask

   task automatic test_two_byte_passthrough;
      send_item(8'hC3, 1'b0);
      send_item(8'hA9, 1'b1);
   endtask

   task automatic test_invalid_leads;
      send_item(8'h80, 1'b0);
      send_item(8'hC0, 1'b0);
      send_item(8'hF0, 1'b0);
      send_item(8'hFF, 1'b1);
   endtask

   task automatic test_broken_sequence;
      send_item(8'hE3, 1'b0);   // lead then ascii where a continuation is due
      send_item(8'h41, 1'b1);
   endtask

   task automatic test_overlong_form;
      send_item(8'hE0, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h80, 1'b1);
   endtask

   task automatic test_surrogate_passthrough;
      send_item(8'hED, 1'b0);
      send_item(8'hA0, 1'b0);
      send_item(8'h80, 1'b1);
   endtask

   task automatic test_line_end_flush;
      send_item(8'hE3, 1'b0);   // two bytes held at end of line
      send_item(8'h81, 1'b1);
      send_item(8'hC3, 1'b1);   // one byte held at end of line
   endtask

   function automatic logic [15:0] pick_listed_cp;
      logic [15:0] cp;
      case ($urandom_range(0, 5))
         0: cp = 16'h3000;
         1: cp = 16'(16'hFF10 + $urandom_range(0, 9));
         2: cp = 16'(16'hFF21 + $urandom_range(0, 2));
         3: cp = 16'(16'hFF41 + $urandom_range(0, 2));
         default: begin
            case ($urandom_range(0, 14))
               0:  cp = 16'hFF08;
               1:  cp = 16'hFF09;
               2:  cp = 16'hFF1A;
               3:  cp = 16'hFF0B;
               4:  cp = 16'hFF20;
               5:  cp = 16'hFF0E;
               6:  cp = 16'hFF0F;
               7:  cp = 16'hFF0D;
               8:  cp = 16'hFF58;
               9:  cp = 16'hFF49;
               10: cp = 16'hFF44;
               11: cp = 16'hFF55;
               12: cp = 16'hFF45;
               13: cp = 16'hFF50;
               default: cp = 16'hFF4E;
            endcase
         end
      endcase
      return cp;
   endfunction

   // random lines: mostly well-formed sequences, some noise and broken ones
   task automatic test_random_lines;
      logic [7:0]   seq[3];
      int           seq_len;
      int           roll;
      seq_kind_type kind;
      logic [15:0]  cp;
      logic         line_end;
      int           sent_here;
      bit           paused;
      sent_here = 0;
      paused    = 1'b0;
      while (sent_here < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 20)      kind = SEQ_ASCII;
         else if (roll < 50) kind = SEQ_LISTED;
         else if (roll < 62) kind = SEQ_THREE;
         else if (roll < 72) kind = SEQ_TWO;
         else if (roll < 86) kind = SEQ_NOISE;
         else                kind = SEQ_BROKEN;
         case (kind)
            SEQ_ASCII: begin
               seq[0]  = 8'($urandom_range(0, 127));
               seq_len = 1;
            end
            SEQ_LISTED, SEQ_THREE: begin
               if (kind == SEQ_LISTED)
                  cp = pick_listed_cp();
               else if ($urandom_range(0, 1) == 0)
                  cp = 16'(16'hFF00 + $urandom_range(0, 16'h5F));   // near the allowlist
               else
                  cp = 16'($urandom_range(0, 16'hFFFF));   // may be overlong
               seq[0]  = {4'hE, cp[15:12]};
               seq[1]  = {2'b10, cp[11:6]};
               seq[2]  = {2'b10, cp[5:0]};
               seq_len = 3;
            end
            SEQ_TWO: begin
               seq[0]  = 8'($urandom_range(8'hC2, 8'hDF));
               seq[1]  = 8'($urandom_range(8'h80, 8'hBF));
               seq_len = 2;
            end
            SEQ_NOISE: begin
               seq[0]  = 8'($urandom_range(0, 255));
               seq_len = 1;
            end
            default: begin
               seq[0]  = 8'($urandom_range(8'hC2, 8'hEF));
               seq_len = 1;
               if (seq[0] >= 8'hE0 && $urandom_range(0, 1) == 0) begin
                  seq[1]  = 8'($urandom_range(8'h80, 8'hBF));
                  seq_len = 2;
               end
               // the breaking byte is ascii or a byte from C0 to FF, never a continuation
               seq[seq_len] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 127))
                                                         : 8'($urandom_range(8'hC0, 8'hFF));
               seq_len++;
            end
         endcase
         for (int i = 0; i < seq_len; i++) begin
            if (i == seq_len - 1)
               line_end = ($urandom_range(0, 5) == 0);
            else
               line_end = ($urandom_range(0, 24) == 0);
            send_item(seq[i], line_end);
            sent_here++;
         end
         if (!paused && sent_here >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
      send_item(8'h2E, 1'b1);   // close the last line
   endtask

   // receiver ready pattern, switching at random between four stall modes
   initial begin
      rsp_tready  = 1'b1;
      stall_mode  = STALL_NONE;
      stall_phase = 0;
      stall_hold  = 0;
      forever begin
         @(negedge clock);
         if (stall_phase == 0) begin
            stall_mode  = stall_kind_type'($urandom_range(0, 3));
            stall_phase = $urandom_range(20, 80);
         end
         stall_phase--;
         case (stall_mode)
            STALL_NONE:  rsp_tready = 1'b1;
            STALL_LIGHT: rsp_tready = ($urandom_range(0, 3) != 0);
            STALL_HEAVY: rsp_tready = ($urandom_range(0, 2) == 0);
            default: begin
               if (stall_hold == 0) begin
                  rsp_tready = ~rsp_tready;
                  stall_hold = $urandom_range(1, 20);
               end
               stall_hold--;
            end
         endcase
      end
   end

   // result checker, compares each accepted item with the oldest queued byte
   rsp_item_type want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t unexpected item: byte %h last %b", $time, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.data) begin
               errors++;
               $display("%0t out_byte mismatch: expected %h actual %h",
                        $time, want.data, rsp_tdata);
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t out_last mismatch: expected %b actual %b",
                        $time, want.last, rsp_tlast);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("%0t timeout with %0d bytes still due", $time, pending_bytes.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      shadow_lead   = 8'h00;
      shadow_second = 8'h00;
      shadow_count  = 2'd0;
      errors        = 0;
      items_sent    = 0;
      results_seen  = 0;
      lines_sent    = 0;
      burst_left    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_ascii_extremes();
      test_listed_codepoints();
      test_two_byte_passthrough();
      test_invalid_leads();
      test_broken_sequence();
      test_overlong_form();
      test_surrogate_passthrough();
      test_line_end_flush();
      test_random_lines();

      release_bus();
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         errors++;
         $display("%0t %0d bytes never came out", $time, pending_bytes.size());
      end

      $display("covered %0d input bytes in %0d lines, %0d output bytes checked",
               items_sent, lines_sent, results_seen);
      $display("mix: ascii, allowlisted codepoints, bad leads, broken, overlong, flushes");
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
